// ===== src/tcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsm_pkg
// Types, codes and helpers shared by the TCP connection control block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsm_pkg;

  localparam int unsigned MaxResults = 45;
  localparam int unsigned CtlSlots   = 3;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagPsh = 8'h08;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic [19:0] WaitMax = 20'hFFFFF;

  typedef enum logic [2:0] {
    KIND_SEGMENT = 3'd0,
    KIND_LISTEN  = 3'd1,
    KIND_CONNECT = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_SEND    = 3'd4,
    KIND_TICK    = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    PH_CLOSED     = 4'd0,
    PH_LISTEN     = 4'd1,
    PH_SYN_SENT   = 4'd2,
    PH_SYN_RCVD   = 4'd3,
    PH_ESTAB      = 4'd4,
    PH_FW1        = 4'd5,
    PH_FW2        = 4'd6,
    PH_CLOSE_WAIT = 4'd7,
    PH_LAST_ACK   = 4'd8,
    PH_TIME_WAIT  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ACT_TRANSMIT = 2'd0,
    ACT_DELIVER  = 2'd1,
    ACT_STATUS   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_ISS      = 2'd0,
    CFG_LOCALWIN = 2'd1,
    CFG_TW_TICKS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [15:0] len;
  } ctl_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
  } dp_status_t;

  function automatic logic serial_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

`default_nettype wire

// ===== src/tcsm_if.sv =====
// ----------------------------------------------------------------------------
// tcsm_in_if / tcsm_out_if
// Valid/ready channels for event words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcsm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  seg_flags;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [15:0] seg_window;
  logic [15:0] data_len;
  modport source (output valid, kind, seg_flags, seg_seq, seg_ack, seg_window, data_len,
                  input ready);
  modport sink (input valid, kind, seg_flags, seg_seq, seg_ack, seg_window, data_len,
                output ready);
endinterface

interface tcsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  tx_flags;
  logic [31:0] tx_seq;
  logic [31:0] tx_ack;
  logic [15:0] tx_window;
  logic [15:0] item_len;
  logic [15:0] data_offset;
  logic [15:0] accepted_len;
  logic [3:0]  conn_state;
  logic        last;
  modport source (output valid, action, tx_flags, tx_seq, tx_ack, tx_window, item_len,
                  data_offset, accepted_len, conn_state, last, input ready);
  modport sink (input valid, action, tx_flags, tx_seq, tx_ack, tx_window, item_len,
                data_offset, accepted_len, conn_state, last, output ready);
endinterface

`default_nettype wire

// ===== src/tcsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcsm_ctrl
// Sequencer: accept one event word, evaluate it, then drain its results.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire tcsm_pkg::dp_status_t status_i,
  output tcsm_pkg::dp_cmd_t        cmd_o
);
  import tcsm_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = CS_EMIT;
      end
      CS_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (status_i.last_word) state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tcsm_dp.sv =====
// ----------------------------------------------------------------------------
// tcsm_dp
// Connection variables, event evaluation and result word generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsm_dp #(
  parameter int unsigned MAX_SEGMENT = 1460
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire tcsm_pkg::dp_cmd_t    cmd_i,
  output tcsm_pkg::dp_status_t      status_o,
  input  wire logic [2:0]           kind_i,
  input  wire logic [7:0]           seg_flags_i,
  input  wire logic [31:0]          seg_seq_i,
  input  wire logic [31:0]          seg_ack_i,
  input  wire logic [15:0]          seg_window_i,
  input  wire logic [15:0]          data_len_i,
  output logic [1:0]                action_o,
  output logic [7:0]                tx_flags_o,
  output logic [31:0]               tx_seq_o,
  output logic [31:0]               tx_ack_o,
  output logic [15:0]               tx_window_o,
  output logic [15:0]               item_len_o,
  output logic [15:0]               data_offset_o,
  output logic [15:0]               accepted_len_o,
  output logic [3:0]                conn_state_o,
  output logic                      last_o
);
  import tcsm_pkg::*;

  localparam logic [31:0] SendCap = 32'(MaxResults * MAX_SEGMENT);
  localparam logic [15:0] Mss     = 16'(MAX_SEGMENT);

  // configuration
  logic [31:0] iss_q;
  logic [15:0] lwin_q;
  logic [19:0] tw_ticks_q;

  // connection variables
  phase_e      phase_q, phase_d;
  logic [31:0] una_q, una_d, nxt_q, nxt_d, rnxt_q, rnxt_d;
  logic [15:0] pwin_q, pwin_d;
  logic [19:0] welap_q, welap_d;

  // latched event word
  logic [2:0]  kind_q;
  logic [7:0]  flags_q;
  logic [31:0] seq_q, ack_q;
  logic [15:0] win_q, len_q;

  // pending results
  ctl_item_t   items_q [CtlSlots];
  ctl_item_t   items_d [CtlSlots];
  logic [1:0]  cnt_q, cnt_d, idx_q;
  logic        send_mode_q;
  logic [15:0] total_d, accepted_q, rem_q, off_q;
  logic [31:0] sseq_q;

  logic [31:0] inflight, seq_end;
  logic [15:0] space, n_cur;
  logic        ack_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q      <= '0;
      lwin_q     <= 16'hFFFF;
      tw_ticks_q <= 20'd60000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ISS:      iss_q      <= cfg_data_i;
        CFG_LOCALWIN: lwin_q     <= cfg_data_i[15:0];
        CFG_TW_TICKS: tw_ticks_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    una_d   = una_q;
    nxt_d   = nxt_q;
    rnxt_d  = rnxt_q;
    pwin_d  = pwin_q;
    welap_d = welap_q;
    cnt_d   = 2'd0;
    total_d = '0;
    for (int i = 0; i < CtlSlots; i++) items_d[i] = '0;
    inflight = nxt_q - una_q;
    space    = ({16'd0, pwin_q} > inflight) ? 16'(32'(pwin_q) - inflight) : 16'd0;
    seq_end  = seq_q + 32'(len_q);
    ack_ok   = serial_lt(una_q, ack_q) && !serial_lt(nxt_q, ack_q);
    case (kind_q)
      KIND_SEGMENT: begin
        case (phase_q)
          PH_CLOSED: begin
            if (!flags_q[2]) begin
              items_d[0] = '{ACT_TRANSMIT, FlagRst | FlagAck,
                             flags_q[4] ? ack_q : 32'd0, seq_q + 32'd1, 16'd0, 16'd0};
              cnt_d = 2'd1;
            end
          end
          PH_LISTEN: begin
            if (!flags_q[2] && flags_q[1]) begin
              rnxt_d  = seq_q + 32'd1;
              pwin_d  = win_q;
              una_d   = iss_q;
              nxt_d   = iss_q + 32'd1;
              phase_d = PH_SYN_RCVD;
              items_d[0] = '{ACT_TRANSMIT, FlagSyn | FlagAck, iss_q, seq_q + 32'd1,
                             lwin_q, 16'd0};
              cnt_d = 2'd1;
            end
          end
          PH_SYN_SENT: begin
            if (flags_q[2]) begin
              phase_d = PH_CLOSED;
            end else if (flags_q[1]) begin
              rnxt_d = seq_q + 32'd1;
              pwin_d = win_q;
              if (flags_q[4]) begin
                if (ack_ok) begin
                  una_d   = ack_q;
                  phase_d = PH_ESTAB;
                  items_d[0] = '{ACT_TRANSMIT, FlagAck, nxt_q, seq_q + 32'd1,
                                 lwin_q, 16'd0};
                  cnt_d = 2'd1;
                end
              end else begin
                phase_d = PH_SYN_RCVD;
                items_d[0] = '{ACT_TRANSMIT, FlagSyn | FlagAck, iss_q, seq_q + 32'd1,
                               lwin_q, 16'd0};
                cnt_d = 2'd1;
              end
            end
          end
          PH_SYN_RCVD: begin
            if (flags_q[2]) begin
              phase_d = PH_CLOSED;
            end else if (flags_q[4] && ack_ok) begin
              una_d   = ack_q;
              phase_d = PH_ESTAB;
            end
          end
          PH_ESTAB, PH_FW1, PH_FW2: begin
            if (flags_q[2]) begin
              phase_d = PH_CLOSED;
            end else begin
              if (flags_q[4]) begin
                if (ack_ok) una_d = ack_q;
                pwin_d = win_q;
              end
              if (len_q != 16'd0 && seq_q == rnxt_q) begin
                rnxt_d = rnxt_q + 32'(len_q);
                items_d[0] = '{ACT_DELIVER, 8'd0, 32'd0, 32'd0, 16'd0, len_q};
                items_d[1] = '{ACT_TRANSMIT, FlagAck, nxt_q, rnxt_d, lwin_q, 16'd0};
                cnt_d = 2'd2;
              end
              if (flags_q[0] && seq_end == rnxt_d) begin
                rnxt_d = rnxt_d + 32'd1;
                items_d[cnt_d] = '{ACT_TRANSMIT, FlagAck, nxt_q, rnxt_d, lwin_q, 16'd0};
                cnt_d = cnt_d + 2'd1;
                if (phase_q == PH_ESTAB) begin
                  phase_d = PH_CLOSE_WAIT;
                end else begin
                  phase_d = PH_TIME_WAIT;
                  welap_d = '0;
                end
              end else if (phase_q == PH_FW1 && una_d == nxt_q) begin
                phase_d = PH_FW2;
              end
            end
          end
          PH_CLOSE_WAIT: begin
            if (flags_q[2]) begin
              phase_d = PH_CLOSED;
            end else if (flags_q[4] && ack_ok) begin
              una_d = ack_q;
            end
          end
          PH_LAST_ACK: begin
            if (flags_q[4] && ack_ok) begin
              una_d   = ack_q;
              phase_d = PH_CLOSED;
            end
          end
          PH_TIME_WAIT: begin
            if (flags_q[0]) begin
              items_d[0] = '{ACT_TRANSMIT, FlagAck, nxt_q, rnxt_q, lwin_q, 16'd0};
              cnt_d   = 2'd1;
              welap_d = '0;
            end
          end
          default: phase_d = PH_CLOSED;
        endcase
      end
      KIND_LISTEN: phase_d = PH_LISTEN;
      KIND_CONNECT: begin
        una_d   = iss_q;
        nxt_d   = iss_q + 32'd1;
        phase_d = PH_SYN_SENT;
        items_d[0] = '{ACT_TRANSMIT, FlagSyn, iss_q, 32'd0, lwin_q, 16'd0};
        cnt_d = 2'd1;
      end
      KIND_CLOSE: begin
        if (phase_q == PH_ESTAB || phase_q == PH_CLOSE_WAIT) begin
          nxt_d   = nxt_q + 32'd1;
          phase_d = (phase_q == PH_ESTAB) ? PH_FW1 : PH_LAST_ACK;
          items_d[0] = '{ACT_TRANSMIT, FlagFin | FlagAck, nxt_q, rnxt_q, lwin_q, 16'd0};
          cnt_d = 2'd1;
        end
      end
      KIND_SEND: begin
        if (phase_q == PH_ESTAB && len_q != 16'd0) begin
          total_d = (len_q < space) ? len_q : space;
          if (32'(total_d) > SendCap) total_d = SendCap[15:0];
          nxt_d = nxt_q + 32'(total_d);
        end
      end
      KIND_TICK: begin
        if (phase_q == PH_TIME_WAIT) begin
          if (welap_q < WaitMax) welap_d = welap_q + 20'd1;
          if (welap_d >= tw_ticks_q) phase_d = PH_CLOSED;
        end
      end
      default: ;
    endcase
    if (cnt_d == 2'd0 && total_d == 16'd0) begin
      items_d[0] = '{ACT_STATUS, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0};
      cnt_d = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLOSED;
      una_q       <= '0;
      nxt_q       <= '0;
      rnxt_q      <= '0;
      pwin_q      <= '0;
      welap_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      send_mode_q <= 1'b0;
    end else if (cmd_i.exec) begin
      phase_q     <= phase_d;
      una_q       <= una_d;
      nxt_q       <= nxt_d;
      rnxt_q      <= rnxt_d;
      pwin_q      <= pwin_d;
      welap_q     <= welap_d;
      cnt_q       <= cnt_d;
      idx_q       <= '0;
      send_mode_q <= (total_d != 16'd0);
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      flags_q <= seg_flags_i;
      seq_q   <= seg_seq_i;
      ack_q   <= seg_ack_i;
      win_q   <= seg_window_i;
      len_q   <= data_len_i;
    end
    if (cmd_i.exec) begin
      items_q    <= items_d;
      accepted_q <= total_d;
      rem_q      <= total_d;
      off_q      <= '0;
      sseq_q     <= nxt_q;
    end else if (cmd_i.advance && send_mode_q) begin
      rem_q  <= rem_q - n_cur;
      off_q  <= off_q + n_cur;
      sseq_q <= sseq_q + 32'(n_cur);
    end
  end

  assign n_cur = (rem_q > Mss) ? Mss : rem_q;

  always_comb begin
    if (send_mode_q) begin
      action_o      = ACT_TRANSMIT;
      tx_flags_o    = FlagAck | FlagPsh;
      tx_seq_o      = sseq_q;
      tx_ack_o      = rnxt_q;
      tx_window_o   = lwin_q;
      item_len_o    = n_cur;
      data_offset_o = off_q;
      last_o        = (rem_q <= Mss);
    end else begin
      action_o      = items_q[idx_q].action;
      tx_flags_o    = items_q[idx_q].flags;
      tx_seq_o      = items_q[idx_q].seq;
      tx_ack_o      = items_q[idx_q].ack;
      tx_window_o   = items_q[idx_q].win;
      item_len_o    = items_q[idx_q].len;
      data_offset_o = 16'd0;
      last_o        = (idx_q == cnt_q - 2'd1);
    end
  end

  assign accepted_len_o     = accepted_q;
  assign conn_state_o       = phase_q;
  assign status_o.last_word = last_o;

endmodule

`default_nettype wire

// ===== src/tcp_connection_state_machine_unit.sv =====
// Event word accepted, evaluated the next cycle, first result word valid the cycle after.
// R results per event word (1..3 for control, up to 45 for send); all drain before the next.
// Sends yield one descriptor per cycle from the segmenting counter while out_ready is high.
// Reset (rst_ni low, async): phase closed, sequence variables zero, config to defaults.
// ----------------------------------------------------------------------------
// tcp_connection_state_machine_unit
// One TCP connection's control block: sequencer plus connection datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_connection_state_machine_unit #(
  parameter int unsigned MAX_SEGMENT = 1460
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  tcsm_in_if.sink          in_if,
  tcsm_out_if.source       out_if
);
  import tcsm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tcsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcsm_dp #(.MAX_SEGMENT(MAX_SEGMENT)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (in_if.kind),
    .seg_flags_i    (in_if.seg_flags),
    .seg_seq_i      (in_if.seg_seq),
    .seg_ack_i      (in_if.seg_ack),
    .seg_window_i   (in_if.seg_window),
    .data_len_i     (in_if.data_len),
    .action_o       (out_if.action),
    .tx_flags_o     (out_if.tx_flags),
    .tx_seq_o       (out_if.tx_seq),
    .tx_ack_o       (out_if.tx_ack),
    .tx_window_o    (out_if.tx_window),
    .item_len_o     (out_if.item_len),
    .data_offset_o  (out_if.data_offset),
    .accepted_len_o (out_if.accepted_len),
    .conn_state_o   (out_if.conn_state),
    .last_o         (out_if.last)
  );

endmodule

`default_nettype wire

// ===== src/tcsm_checker.sv =====
// ----------------------------------------------------------------------------
// tcsm_checker
// Port-level checks on the connection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] action,
  input wire logic [3:0] conn_state,
  input wire logic       last
);

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while results pending");

  a_eval_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("no evaluation cycle after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("result word dropped");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && action == tcsm_pkg::ACT_STATUS) |-> last)
    else $error("status word not last");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (conn_state <= tcsm_pkg::PH_TIME_WAIT)) else $error("bad phase");

endmodule

bind tcp_connection_state_machine_unit tcsm_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .action     (out_if.action),
  .conn_state (out_if.conn_state),
  .last       (out_if.last)
);

`default_nettype wire
